>>> sv/ip6tb_pkg.sv
// Shared types and constants for the IPv6 text to binary unit.
package ip6tb_pkg;

  // Address geometry.
  localparam int unsigned NumGroups = 8;
  localparam int unsigned GroupW    = 16;
  localparam int unsigned MaxDigits = 4;

  // Character codes of interest.
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;

  typedef logic [GroupW-1:0] group_t;
  typedef group_t [NumGroups-1:0] group_arr_t;

  // One character of address text.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  // One expanded address.
  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        parse_error;
  } out_t;

endpackage

>>> sv/ip6tb_place.sv
// Placement of the stored groups around the zero-filled gap.
module ip6tb_place (
  input  ip6tb_pkg::group_arr_t groups_i,
  input  logic [3:0]            count_i,
  input  logic                  gap_seen_i,
  input  logic [3:0]            gap_pos_i,
  output logic [63:0]           addr_high_o,
  output logic [63:0]           addr_low_o
);

  logic [3:0]            pos_c;
  logic [3:0]            zeros_c;
  logic [4:0]            gap_end_c;
  ip6tb_pkg::group_arr_t full_c;

  // Gap starts at the double colon, or after the last group if there was none.
  always_comb begin
    if (gap_seen_i && (gap_pos_i <= count_i)) begin
      pos_c = gap_pos_i;
    end else begin
      pos_c = count_i;
    end
    zeros_c   = 4'(ip6tb_pkg::NumGroups) - count_i;
    gap_end_c = {1'b0, pos_c} + {1'b0, zeros_c};
  end

  // Each output slot takes a group before the gap, a zero, or a group after it.
  always_comb begin
    for (int i = 0; i < ip6tb_pkg::NumGroups; i++) begin
      if (4'(i) < pos_c) begin
        full_c[i] = groups_i[3'(i)];
      end else if (5'(i) < gap_end_c) begin
        full_c[i] = '0;
      end else begin
        full_c[i] = groups_i[3'(i) - zeros_c[2:0]];
      end
    end
  end

  assign addr_high_o = {full_c[0], full_c[1], full_c[2], full_c[3]};
  assign addr_low_o  = {full_c[4], full_c[5], full_c[6], full_c[7]};

endmodule

>>> sv/ipv6_text_to_binary_unit.sv
// Top level of the IPv6 text to binary unit.
//
// The input channel carries one character of IPv6 address text per
// transfer, with last_char marking the final character of an address.
// Hex digits are gathered into 16-bit groups, colons close groups and a
// double colon marks where the zero gap goes. No result is produced for
// ordinary characters; the transfer carrying last_char yields one result on
// the output channel: the 128-bit address as two 64-bit halves and a
// parse_error flag (too many digits, too many groups, or a bad character).
// One character is taken every cycle unless the input is stalled. The result
// appears in the output register in the cycle after the last character's
// transfer; per-character update and eight-way placement are combinational.
// Reset clears the parser control state and the output valid; a new address may
// start straight away. While a result is held in the output register and the
// receiver stalls, the input channel is stalled too; otherwise input
// transfers continue while the result waits.
module ipv6_text_to_binary_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ip6tb_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ip6tb_pkg::out_t out_data_o
);

  // Parser state.
  ip6tb_pkg::group_arr_t store_q;
  ip6tb_pkg::group_t     acc_q, acc_d;
  logic [2:0]            dcount_q, dcount_d;
  logic [3:0]            gcount_q, gcount_d;
  logic [3:0]            gap_pos_q, gap_pos_d;
  logic                  gap_seen_q, gap_seen_d;
  logic                  prev_colon_q, prev_colon_d;
  logic                  err_q, err_d;

  // Result register.
  logic                  out_valid_q;
  ip6tb_pkg::out_t       out_q, out_d;

  logic                  accept;
  logic                  is_digit, is_colon;
  logic [3:0]            digit_val;
  logic                  wr_en;
  logic [2:0]            wr_idx;
  ip6tb_pkg::group_t     wr_val;
  ip6tb_pkg::group_arr_t store_c;
  logic [63:0]           addr_high_c, addr_low_c;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Character class and hex value.
  always_comb begin
    is_colon  = (in_data_i.char_code == ip6tb_pkg::ChColon);
    is_digit  = 1'b1;
    digit_val = '0;
    if ((in_data_i.char_code >= ip6tb_pkg::ChZero) &&
        (in_data_i.char_code <= ip6tb_pkg::ChNine)) begin
      digit_val = 4'(in_data_i.char_code - ip6tb_pkg::ChZero);
    end else if ((in_data_i.char_code >= ip6tb_pkg::ChUpA) &&
                 (in_data_i.char_code <= ip6tb_pkg::ChUpF)) begin
      digit_val = 4'(in_data_i.char_code - ip6tb_pkg::ChUpA) + 4'd10;
    end else if ((in_data_i.char_code >= ip6tb_pkg::ChLowA) &&
                 (in_data_i.char_code <= ip6tb_pkg::ChLowF)) begin
      digit_val = 4'(in_data_i.char_code - ip6tb_pkg::ChLowA) + 4'd10;
    end else begin
      is_digit = 1'b0;
    end
  end

  // Per-character update, then the closing of a pending group on the last
  // character. At most one group is closed per character.
  always_comb begin
    acc_d        = acc_q;
    dcount_d     = dcount_q;
    gcount_d     = gcount_q;
    gap_pos_d    = gap_pos_q;
    gap_seen_d   = gap_seen_q;
    prev_colon_d = prev_colon_q;
    err_d        = err_q;
    wr_en        = 1'b0;
    wr_idx       = gcount_q[2:0];
    wr_val       = acc_q;

    if (is_digit) begin
      if (dcount_q < 3'(ip6tb_pkg::MaxDigits)) begin
        acc_d    = {acc_q[11:0], digit_val};
        dcount_d = dcount_q + 3'd1;
      end else begin
        err_d = 1'b1;
      end
      prev_colon_d = 1'b0;
    end else if (is_colon) begin
      if (dcount_q != '0) begin
        if (gcount_q < 4'(ip6tb_pkg::NumGroups)) begin
          wr_en    = 1'b1;
          gcount_d = gcount_q + 4'd1;
        end else begin
          err_d = 1'b1;
        end
        acc_d    = '0;
        dcount_d = '0;
      end
      if (prev_colon_q && !gap_seen_q) begin
        gap_seen_d = 1'b1;
        gap_pos_d  = gcount_d;
      end
      prev_colon_d = 1'b1;
    end else begin
      err_d = 1'b1;
    end

    // Close the pending group at the end of the address.
    if (in_data_i.last_char && (dcount_d != '0)) begin
      if (gcount_d < 4'(ip6tb_pkg::NumGroups)) begin
        wr_en    = 1'b1;
        wr_idx   = gcount_d[2:0];
        wr_val   = acc_d;
        gcount_d = gcount_d + 4'd1;
      end else begin
        err_d = 1'b1;
      end
    end
  end

  // Group store as seen after this character's write.
  always_comb begin
    store_c = store_q;
    if (wr_en) begin
      store_c[wr_idx] = wr_val;
    end
  end

  ip6tb_place u_place (
    .groups_i    (store_c),
    .count_i     (gcount_d),
    .gap_seen_i  (gap_seen_d),
    .gap_pos_i   (gap_pos_d),
    .addr_high_o (addr_high_c),
    .addr_low_o  (addr_low_c)
  );

  always_comb begin
    out_d.addr_high   = addr_high_c;
    out_d.addr_low    = addr_low_c;
    out_d.parse_error = err_d;
  end

  // Group store: payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      store_q[wr_idx] <= wr_val;
    end
  end

  // Parser control state; cleared after each address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      dcount_q     <= '0;
      gcount_q     <= '0;
      gap_pos_q    <= '0;
      gap_seen_q   <= 1'b0;
      prev_colon_q <= 1'b0;
      err_q        <= 1'b0;
    end else if (accept) begin
      if (in_data_i.last_char) begin
        acc_q        <= '0;
        dcount_q     <= '0;
        gcount_q     <= '0;
        gap_pos_q    <= '0;
        gap_seen_q   <= 1'b0;
        prev_colon_q <= 1'b0;
        err_q        <= 1'b0;
      end else begin
        acc_q        <= acc_d;
        dcount_q     <= dcount_d;
        gcount_q     <= gcount_d;
        gap_pos_q    <= gap_pos_d;
        gap_seen_q   <= gap_seen_d;
        prev_colon_q <= prev_colon_d;
        err_q        <= err_d;
      end
    end
  end

  // Output valid: loads when the slot is free or being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= accept && in_data_i.last_char;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.last_char) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
